### rtl/ittf_pkg.sv
package ittf_pkg;

	// Fixed field widths
	localparam int MAG_W   = 64;
	localparam int FIELD_W = 6;
	localparam int RADIX_W = 2;
	localparam int CHAR_W  = 8;

	// Parameter defaults
	localparam int MAX_FIELD_DEF    = 32;
	localparam int DIGIT_BUFFER_DEF = 24;

	// Decimal conversion: two binary bits per step
	localparam int CONV_STEPS = MAG_W / 2;
	localparam int CONV_CNT_W = $clog2(CONV_STEPS);

	// Radix codes; any other code is decimal
	localparam logic [RADIX_W-1:0] RADIX_DEC = 2'd0;
	localparam logic [RADIX_W-1:0] RADIX_HEX = 2'd1;
	localparam logic [RADIX_W-1:0] RADIX_OCT = 2'd2;

	// ASCII codes
	localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;
		logic conv;
		logic scan;
		logic setup;
		logic emit;
	} ittf_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic dec;
		logic r_zero;
	} ittf_stat_t;

	// Map a digit value to its character, "0123456789abcdef" or capitals
	function automatic logic [CHAR_W-1:0] dig_char(input logic [3:0] d, input logic upper);
		logic [CHAR_W-1:0] base;
		base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
		if (d < 4'd10)
			return CHAR_ZERO + CHAR_W'(d);
		else
			return base + CHAR_W'(d - 4'd10);
	endfunction

endpackage

### rtl/ittf_in_if.sv
interface ittf_in_if;
	logic                               valid;
	logic                               ready;
	logic [ittf_pkg::MAG_W-1:0]         magnitude;
	logic                               is_negative;
	logic [ittf_pkg::RADIX_W-1:0]       radix_select;
	logic                               upper_case;
	logic [ittf_pkg::FIELD_W-1:0]       field_width;
	logic                               zero_pad;
	logic [ittf_pkg::FIELD_W-1:0]       prec_digits;

	modport source (
		output valid, magnitude, is_negative, radix_select, upper_case,
		       field_width, zero_pad, prec_digits,
		input  ready
	);
	modport sink (
		input  valid, magnitude, is_negative, radix_select, upper_case,
		       field_width, zero_pad, prec_digits,
		output ready
	);
endinterface

### rtl/ittf_out_if.sv
interface ittf_out_if;
	logic                          valid;
	logic                          ready;
	logic [ittf_pkg::CHAR_W-1:0]   out_char;
	logic                          last_char;

	modport source (
		output valid, out_char, last_char,
		input  ready
	);
	modport sink (
		input  valid, out_char, last_char,
		output ready
	);
endinterface

### rtl/ittf_ctrl.sv
module ittf_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  ittf_pkg::ittf_stat_t stat,
	output ittf_pkg::ittf_cmd_t  cmd
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_CONV  = 5'b00010,
		ST_SCAN  = 5'b00100,
		ST_SETUP = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	state_t                          state_q, state_d;
	logic [ittf_pkg::CONV_CNT_W-1:0] step_q;
	logic                            out_valid_q;
	logic                            accept;
	logic                            slot_free;
	logic                            conv_last;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign conv_last = (step_q == ittf_pkg::CONV_CNT_W'(ittf_pkg::CONV_STEPS - 1));
	assign out_valid = out_valid_q;

	// Decode commands
	always_comb begin
		cmd       = '0;
		cmd.load  = accept;
		cmd.conv  = (state_q == ST_CONV);
		cmd.scan  = (state_q == ST_SCAN);
		cmd.setup = (state_q == ST_SETUP);
		cmd.emit  = (state_q == ST_EMIT) && slot_free;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept)
					state_d = stat.dec ? ST_CONV : ST_SCAN;
			end
			ST_CONV: begin
				if (conv_last)
					state_d = ST_SCAN;
			end
			ST_SCAN:  state_d = ST_SETUP;
			ST_SETUP: state_d = ST_EMIT;
			ST_EMIT: begin
				if (slot_free && stat.r_zero)
					state_d = ST_IDLE;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// Hold state, step count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept)
				step_q <= '0;
			else if (cmd.conv)
				step_q <= step_q + 1'b1;
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

### rtl/ittf_dp.sv
module ittf_dp #(
	parameter int MAX_FIELD    = ittf_pkg::MAX_FIELD_DEF,
	parameter int DIGIT_BUFFER = ittf_pkg::DIGIT_BUFFER_DEF
) (
	input  logic                          clk,
	input  logic [ittf_pkg::MAG_W-1:0]    magnitude,
	input  logic                          is_negative,
	input  logic [ittf_pkg::RADIX_W-1:0]  radix_select,
	input  logic                          upper_case,
	input  logic [ittf_pkg::FIELD_W-1:0]  field_width,
	input  logic                          zero_pad,
	input  logic [ittf_pkg::FIELD_W-1:0]  prec_digits,
	input  ittf_pkg::ittf_cmd_t           cmd,
	output ittf_pkg::ittf_stat_t          stat,
	output logic [ittf_pkg::CHAR_W-1:0]   out_char,
	output logic                          last_char
);

	localparam int MAXV  = (MAX_FIELD > DIGIT_BUFFER) ? MAX_FIELD : DIGIT_BUFFER;
	localparam int CNT_W = $clog2(MAXV + 2);
	localparam int IDX_W = $clog2(DIGIT_BUFFER);
	localparam int EXT_W = 4 * DIGIT_BUFFER;
	localparam int MAG_W = ittf_pkg::MAG_W;
	localparam int FW    = ittf_pkg::FIELD_W;

	logic [3:0]                   dig_q [DIGIT_BUFFER];
	logic [MAG_W-1:0]             bin_q;
	logic                         neg_q;
	logic                         zpad_q;
	logic                         upper_q;
	logic [FW-1:0]                width_q;
	logic [FW-1:0]                mind_q;
	logic [CNT_W-1:0]             nd_q;
	logic [CNT_W-1:0]             thz_q;
	logic [CNT_W-1:0]             r_q;
	logic [ittf_pkg::CHAR_W-1:0]  char_q;
	logic                         last_q;

	logic [EXT_W-1:0]             ext;
	logic [3:0]                   ld_dig [DIGIT_BUFFER];
	logic [3:0]                   a0 [DIGIT_BUFFER];
	logic [3:0]                   s0 [DIGIT_BUFFER];
	logic [3:0]                   a1 [DIGIT_BUFFER];
	logic [3:0]                   s1 [DIGIT_BUFFER];
	logic [CNT_W-1:0]             nd_c;
	logic [CNT_W-1:0]             thz_c;
	logic [CNT_W-1:0]             rstart_c;
	logic [ittf_pkg::CHAR_W-1:0]  char_c;
	logic                         is_dec;

	assign is_dec = (radix_select != ittf_pkg::RADIX_HEX) &&
	                (radix_select != ittf_pkg::RADIX_OCT);
	assign stat.dec    = is_dec;
	assign stat.r_zero = (r_q == '0);
	assign out_char    = char_q;
	assign last_char   = last_q;

	// Split hex or octal magnitude into digits
	always_comb begin
		ext = EXT_W'(magnitude);
		for (int i = 0; i < DIGIT_BUFFER; i++) begin
			if (radix_select == ittf_pkg::RADIX_HEX)
				ld_dig[i] = ext[4*i +: 4];
			else
				ld_dig[i] = {1'b0, ext[3*i +: 3]};
		end
	end

	// Double-dabble step: two binary bits into the BCD digits
	always_comb begin
		for (int i = 0; i < DIGIT_BUFFER; i++)
			a0[i] = (dig_q[i] >= 4'd5) ? dig_q[i] + 4'd3 : dig_q[i];
		s0[0] = {a0[0][2:0], bin_q[MAG_W-1]};
		for (int i = 1; i < DIGIT_BUFFER; i++)
			s0[i] = {a0[i][2:0], a0[i-1][3]};
		for (int i = 0; i < DIGIT_BUFFER; i++)
			a1[i] = (s0[i] >= 4'd5) ? s0[i] + 4'd3 : s0[i];
		s1[0] = {a1[0][2:0], bin_q[MAG_W-2]};
		for (int i = 1; i < DIGIT_BUFFER; i++)
			s1[i] = {a1[i][2:0], a1[i-1][3]};
	end

	// Count significant digits, at least one
	always_comb begin
		nd_c = CNT_W'(1);
		for (int i = 1; i < DIGIT_BUFFER; i++)
			if (dig_q[i] != 4'd0)
				nd_c = CNT_W'(i + 1);
	end

	// Lay out the field: zero threshold and start position
	always_comb begin
		logic [CNT_W-1:0] mv, wv, numd, total, pad, zprec, zp;
		mv    = CNT_W'(mind_q);
		wv    = CNT_W'(width_q);
		numd  = (nd_q < mv) ? mv : nd_q;
		total = numd + CNT_W'(neg_q);
		pad   = (wv > total) ? wv - total : '0;
		zprec = (mv > nd_q) ? mv - nd_q : '0;
		zp    = zprec + (zpad_q ? pad : '0);
		thz_c    = nd_q + zp;
		rstart_c = total + pad - 1'b1;
	end

	// Pick the character at the current position, counted from the right
	always_comb begin
		if (r_q < nd_q)
			char_c = ittf_pkg::dig_char(dig_q[r_q[IDX_W-1:0]], upper_q);
		else if (r_q < thz_q)
			char_c = ittf_pkg::CHAR_ZERO;
		else if (neg_q && (r_q == thz_q))
			char_c = ittf_pkg::CHAR_MINUS;
		else
			char_c = ittf_pkg::CHAR_SPACE;
	end

	// Load, convert, lay out and advance
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q   <= is_negative;
			zpad_q  <= zero_pad;
			upper_q <= upper_case;
			width_q <= (field_width > FW'(MAX_FIELD)) ? FW'(MAX_FIELD) : field_width;
			mind_q  <= (prec_digits > FW'(MAX_FIELD)) ? FW'(MAX_FIELD) : prec_digits;
			bin_q   <= magnitude;
			for (int i = 0; i < DIGIT_BUFFER; i++)
				dig_q[i] <= is_dec ? 4'd0 : ld_dig[i];
		end
		if (cmd.conv) begin
			bin_q <= {bin_q[MAG_W-3:0], 2'b00};
			for (int i = 0; i < DIGIT_BUFFER; i++)
				dig_q[i] <= s1[i];
		end
		if (cmd.scan)
			nd_q <= nd_c;
		if (cmd.setup) begin
			thz_q <= thz_c;
			r_q   <= rstart_c;
		end
		if (cmd.emit) begin
			char_q <= char_c;
			last_q <= (r_q == '0);
			r_q    <= r_q - 1'b1;
		end
	end

endmodule

### rtl/integer_to_text_formatter.sv
// Formats one unsigned 64-bit magnitude with a sign flag as printf-style text and sends
// it out one ASCII character per transaction, last_char set on the final one. Order:
// leading spaces (space padding), '-', width zeros (zero padding), precision zeros,
// digits most significant first; field_width and prec_digits saturate at MAX_FIELD,
// radix code 3 is decimal, zero prints as one '0'. One item is in work at a time: an
// item is accepted, its digits are counted and the field is laid out, and then it is
// sent at one cycle per character (the larger of field_width and the digit count raised
// to prec_digits plus sign) while the receiver accepts from the single output register.
// Decimal items first pass through the double-dabble unit, which shifts two magnitude
// bits per cycle into the digit register; hex and octal digits are sliced straight from
// the magnitude. A new item is taken once the last character of the previous one sits
// in the output register.
module integer_to_text_formatter #(
	parameter int MAX_FIELD    = ittf_pkg::MAX_FIELD_DEF,
	parameter int DIGIT_BUFFER = ittf_pkg::DIGIT_BUFFER_DEF
) (
	input logic      clk,
	input logic      arst_n,
	ittf_in_if.sink  item,
	ittf_out_if.source text
);

	ittf_pkg::ittf_cmd_t  cmd;
	ittf_pkg::ittf_stat_t stat;
	logic                 in_ready;
	logic                 out_valid;

	ittf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (text.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	ittf_dp #(
		.MAX_FIELD    (MAX_FIELD),
		.DIGIT_BUFFER (DIGIT_BUFFER)
	) u_dp (
		.clk          (clk),
		.magnitude    (item.magnitude),
		.is_negative  (item.is_negative),
		.radix_select (item.radix_select),
		.upper_case   (item.upper_case),
		.field_width  (item.field_width),
		.zero_pad     (item.zero_pad),
		.prec_digits  (item.prec_digits),
		.cmd          (cmd),
		.stat         (stat),
		.out_char     (text.out_char),
		.last_char    (text.last_char)
	);

	assign item.ready = in_ready;
	assign text.valid = out_valid;

endmodule
